[rtl/core/twc_pkg.sv]
// Shared types and constants for the text console writer.
// Used by twc_ctrl, twc_datapath and text_console_writer_unit; no dependencies.
package twc_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam logic [15:0] BLANK_CELL   = 16'h0720;
    localparam logic [7:0]  NEWLINE_CODE = 8'd10;

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] char_code;
        logic [4:0] cell_row;
        logic [6:0] cell_column;
    } in_item_t;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [4:0]  cursor_row_out;
        logic [6:0]  cursor_column_out;
        logic        scrolled;
        logic        bad_address;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture the input beat
        logic exec;     // carry out the held item
        logic fill;     // blank one cell of the cursor row
        logic respond;  // move the result into the output register
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_fill; // held item writes into a row not yet blanked
        logic fill_done; // last cell of the row fill
        logic out_open;  // output register can take a result this cycle
    } dp_status_t;

endpackage

[rtl/core/text_console_writer_unit.sv]
// Top level of the text console writer: port wiring of controller and datapath.
// Depends on twc_pkg, twc_ctrl and twc_datapath.
//
// Text-mode console engine holding a ROWS x COLUMNS grid of 16-bit cells
// (character low byte, attribute high byte) and a cursor. Each input beat is
// one command (put, read, clear) and yields exactly one result beat carrying
// the read cell, the cursor after the command and scroll / bad-address flags.
// Rows live in a ring: a scroll only moves the ring's top pointer, and clear
// or scroll just mark rows as blank in a per-row valid vector, so neither walks
// the buffer. An ordinary command executes in the cell memory (one write port,
// one read port), then loads the output register once it is free; a new beat
// is taken in the cycle the previous result is loaded. Before the first
// character put into a row marked blank is written, the controller spots the
// blank row, then makes one memory write per cell to blank it. No clearing
// pass is needed after reset: reset marks every row blank. text_color may be
// written only while no command is in flight; cfg_ready is always high.
module text_console_writer_unit
    import twc_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    // command channel
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_data,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data,
    // text_color write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    assign cfg_ready = 1'b1;

    twc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    twc_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

[rtl/core/twc_ctrl.sv]
// Controller state machine for the text console writer.
// Depends on twc_pkg; drives the command struct of twc_datapath.
module twc_ctrl
    import twc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t sts,
    output ctrl_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_FILL = 2'd2;
    localparam logic [1:0] ST_RESP = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       take;

    // a new item enters when idle, or as the previous result leaves
    assign in_stall = !((state_reg == ST_IDLE) || ((state_reg == ST_RESP) && sts.out_open));
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cmd.load   = take;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.need_fill)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_FILL:
            begin
                cmd.fill = 1'b1;
                if (sts.fill_done)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_RESP:
            begin
                if (sts.out_open)
                begin
                    cmd.respond = 1'b1;
                    state_next  = take ? ST_EXEC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/twc_datapath.sv]
// Datapath for the text console writer: cell memory, cursor, row ring, result register.
// Depends on twc_pkg; sequenced by twc_ctrl through ctrl_cmd_t.
module twc_datapath
    import twc_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   in_data,
    input  logic       cfg_write,
    input  logic [7:0] cfg_data,
    input  logic       out_stall,
    output logic       out_valid,
    output out_item_t  out_data,
    input  ctrl_cmd_t  cmd,
    output dp_status_t sts
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
    localparam logic [RW:0]   ROWS_X   = (RW + 1)'(ROWS);
    localparam logic [5:0]    ROWS_LIM = 6'(ROWS);
    localparam logic [7:0]    COLS_LIM = 8'(COLUMNS);

    // logical row -> physical row of the ring
    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                               input logic [RW-1:0] lrow);
        logic [RW:0] s;
        s = {1'b0, top} + {1'b0, lrow};
        if (s >= ROWS_X)
        begin
            s = s - ROWS_X;
        end
        return s[RW-1:0];
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
                                                input logic [CW-1:0] col);
        return AW'(prow) * AW'(COLUMNS) + AW'(col);
    endfunction

    logic [15:0]     mem [CELLS];
    logic [15:0]     mem_q;
    logic            mem_we;
    logic            mem_re;
    logic [AW-1:0]   mem_waddr;
    logic [AW-1:0]   mem_raddr;
    logic [15:0]     mem_wdata;

    in_item_t        item_reg;
    logic [RW-1:0]   cur_row_reg, cur_row_next;
    logic [CW-1:0]   cur_col_reg, cur_col_next;
    logic [RW-1:0]   top_reg, top_next;
    logic [ROWS-1:0] row_valid_reg, row_valid_next;
    logic [7:0]      text_color_reg;
    logic [CW-1:0]   fill_cnt_reg, fill_cnt_next;
    logic            scrolled_reg, scrolled_next;
    logic            bad_reg, bad_next;
    logic            is_read_reg, is_read_next;
    logic            rd_live_reg, rd_live_next;
    logic            out_valid_reg, out_valid_next;
    out_item_t       out_data_reg;

    logic [RW-1:0]   phys_cur;
    logic [RW-1:0]   phys_rd;
    logic            put_char;
    logic            newline;
    logic            rd_in_range;
    logic            wrap;

    assign phys_cur    = phys_row(top_reg, cur_row_reg);
    assign rd_in_range = ({1'b0, item_reg.cell_row} < ROWS_LIM)
                      && ({1'b0, item_reg.cell_column} < COLS_LIM);
    assign phys_rd     = phys_row(top_reg, item_reg.cell_row[RW-1:0]);
    assign put_char    = (item_reg.command == CMD_PUT) && (item_reg.char_code != NEWLINE_CODE);
    assign newline     = (item_reg.command == CMD_PUT) && (item_reg.char_code == NEWLINE_CODE);

    assign sts.need_fill = put_char && !row_valid_reg[phys_cur];
    assign sts.fill_done = (fill_cnt_reg == LAST_COL);
    assign sts.out_open  = !out_valid_reg || !out_stall;

    always_comb
    begin
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        top_next       = top_reg;
        row_valid_next = row_valid_reg;
        fill_cnt_next  = fill_cnt_reg;
        scrolled_next  = scrolled_reg;
        bad_next       = bad_reg;
        is_read_next   = is_read_reg;
        rd_live_next   = rd_live_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = cell_addr(phys_cur, cur_col_reg);
        mem_raddr      = cell_addr(phys_rd, item_reg.cell_column[CW-1:0]);
        mem_wdata      = {text_color_reg, item_reg.char_code};
        wrap           = 1'b0;

        if (cmd.fill)
        begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(phys_cur, fill_cnt_reg);
            mem_wdata = BLANK_CELL;
            if (sts.fill_done)
            begin
                fill_cnt_next            = '0;
                row_valid_next[phys_cur] = 1'b1;
            end
            else
            begin
                fill_cnt_next = fill_cnt_reg + 1'b1;
            end
        end

        if (cmd.exec)
        begin
            scrolled_next = 1'b0;
            bad_next      = 1'b0;
            is_read_next  = (item_reg.command == CMD_READ);
            rd_live_next  = 1'b0;
            case (item_reg.command)
                CMD_PUT:
                begin
                    if (newline)
                    begin
                        wrap = 1'b1;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        if (cur_col_reg == LAST_COL)
                        begin
                            wrap = 1'b1;
                        end
                        else
                        begin
                            cur_col_next = cur_col_reg + 1'b1;
                        end
                    end
                end
                CMD_READ:
                begin
                    mem_re       = rd_in_range;
                    bad_next     = !rd_in_range;
                    rd_live_next = rd_in_range && row_valid_reg[phys_rd];
                end
                CMD_CLEAR:
                begin
                    row_valid_next = '0;
                    cur_row_next   = '0;
                    cur_col_next   = '0;
                end
                default:
                begin
                end
            endcase

            if (wrap)
            begin
                cur_col_next = '0;
                if (cur_row_reg == LAST_ROW)
                begin
                    // old top row becomes the blank bottom row
                    scrolled_next           = 1'b1;
                    row_valid_next[top_reg] = 1'b0;
                    top_next                = (top_reg == LAST_ROW) ? '0 : top_reg + 1'b1;
                end
                else
                begin
                    cur_row_next = cur_row_reg + 1'b1;
                end
            end
        end

        if (cmd.respond)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (cmd.respond)
        begin
            out_data_reg.cell_value        <= (is_read_reg && !bad_reg)
                                            ? (rd_live_reg ? mem_q : BLANK_CELL) : 16'd0;
            out_data_reg.cursor_row_out    <= 5'(cur_row_reg);
            out_data_reg.cursor_column_out <= 7'(cur_col_reg);
            out_data_reg.scrolled          <= scrolled_reg;
            out_data_reg.bad_address       <= bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            top_reg        <= '0;
            row_valid_reg  <= '0;
            text_color_reg <= 8'h07;
            fill_cnt_reg   <= '0;
            scrolled_reg   <= 1'b0;
            bad_reg        <= 1'b0;
            is_read_reg    <= 1'b0;
            rd_live_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            top_reg       <= top_next;
            row_valid_reg <= row_valid_next;
            fill_cnt_reg  <= fill_cnt_next;
            scrolled_reg  <= scrolled_next;
            bad_reg       <= bad_next;
            is_read_reg   <= is_read_next;
            rd_live_reg   <= rd_live_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                text_color_reg <= cfg_data;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_fill_unfilled_row: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill |-> !row_valid_reg[phys_cur])
        else $error("row fill on a row already blanked");

    a_char_into_live_row: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && put_char) |-> row_valid_reg[phys_cur])
        else $error("character written into an unfilled row");

    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.respond |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a pending beat");

    a_cursor_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_row_reg <= LAST_ROW) && (top_reg <= LAST_ROW))
        else $error("cursor row or ring top out of range");

    a_cursor_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_col_reg <= LAST_COL)
        else $error("cursor column out of range");

endmodule
